// ===== rtl/signal_subscription_table_assert.svh =====
// Assertion macros shared by the signal subscription table RTL.
// Every macro samples on the rising edge of the port named clock.
`ifndef SIGNAL_SUBSCRIPTION_TABLE_ASSERT_SVH
`define SIGNAL_SUBSCRIPTION_TABLE_ASSERT_SVH

// Checked only while reset is low.
`define SST_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define SST_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/sst_pkg.sv =====
// Package for the signal subscription table: sizes, request and status codes,
// and the beat record that travels along the slot cells. No dependencies.
`default_nettype none

package sst_pkg;

   localparam int SLOTS      = 16;
   localparam int COUNT_BITS = 16;
   localparam int SLOT_BITS  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam int OP_W    = 3;
   localparam int KIND_W  = 4;
   localparam int HSLOT_W = 8;
   localparam int GEN_W   = 32;
   localparam int CNT_W   = 16;
   localparam int ST_W    = 2;
   localparam int MASK_W  = 16;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 64;

   localparam logic [MASK_W-1:0] MASK_RESET = MASK_W'(3);

   localparam logic [OP_W-1:0] OP_SUBSCRIBE   = 3'd0;
   localparam logic [OP_W-1:0] OP_POLL        = 3'd1;
   localparam logic [OP_W-1:0] OP_UNSUBSCRIBE = 3'd2;
   localparam logic [OP_W-1:0] OP_RAISE       = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR_SHUT  = 3'd4;
   localparam logic [OP_W-1:0] OP_CLEAR_ALL   = 3'd5;

   localparam logic [ST_W-1:0] ST_OK        = 2'd0;
   localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [ST_W-1:0] ST_PENDING   = 2'd2;
   localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic                  valid;
      logic [OP_W-1:0]       op;
      logic [KIND_W-1:0]     kind;
      logic [HSLOT_W-1:0]    hslot;
      logic [GEN_W-1:0]      hgen;
      logic                  claimed;
      logic [ST_W-1:0]       status;
      logic [HSLOT_W-1:0]    nslot;
      logic [GEN_W-1:0]      ngen;
      logic [COUNT_BITS-1:0] cnt;
   } token_type;

endpackage

`default_nettype wire

// ===== rtl/sst_cell.sv =====
// One slot of the subscription table: holds the slot state, applies the passing
// request beat to it and hands the beat on to the next cell. Uses sst_pkg.
`default_nettype none

module sst_cell (
   input  wire                          clock,
   input  wire                          reset,
   input  wire [sst_pkg::SLOT_BITS-1:0] cell_index,
   input  wire sst_pkg::token_type      tok_in,
   output sst_pkg::token_type           tok_out
);
   import sst_pkg::*;

   logic                  alive_ff, alive_in;
   logic [KIND_W-1:0]     kind_ff, kind_in;
   logic [GEN_W-1:0]      gen_ff, gen_in;
   logic [COUNT_BITS-1:0] pend_ff, pend_in;
   token_type             tok_ff, tok_in_next;
   logic                  hit;
   logic [GEN_W-1:0]      gen_next;

   assign hit = (tok_in.hslot == HSLOT_W'(cell_index)) && alive_ff &&
                (gen_ff == tok_in.hgen);
   assign gen_next = (gen_ff == {GEN_W{1'b1}}) ? GEN_W'(1) : gen_ff + GEN_W'(1);

   always_comb begin
      alive_in    = alive_ff;
      kind_in     = kind_ff;
      gen_in      = gen_ff;
      pend_in     = pend_ff;
      tok_in_next = tok_in;
      if (tok_in.valid) begin
         case (tok_in.op)
            OP_SUBSCRIBE: begin
               if (!tok_in.claimed && !alive_ff) begin
                  alive_in            = 1'b1;
                  kind_in             = tok_in.kind;
                  gen_in              = gen_next;
                  pend_in             = '0;
                  tok_in_next.claimed = 1'b1;
                  tok_in_next.status  = ST_OK;
                  tok_in_next.nslot   = HSLOT_W'(cell_index);
                  tok_in_next.ngen    = gen_next;
               end
            end
            OP_POLL: begin
               if (hit) begin
                  if (pend_ff == '0) begin
                     tok_in_next.status = ST_PENDING;
                  end else begin
                     tok_in_next.status = ST_OK;
                     tok_in_next.cnt    = pend_ff;
                     pend_in            = '0;
                  end
               end
            end
            OP_UNSUBSCRIBE: begin
               if (hit) begin
                  alive_in           = 1'b0;
                  tok_in_next.status = ST_OK;
               end
            end
            OP_RAISE: begin
               if (alive_ff && (kind_ff == tok_in.kind) && (pend_ff != {COUNT_BITS{1'b1}})) begin
                  pend_in = pend_ff + COUNT_BITS'(1);
               end
            end
            OP_CLEAR_ALL: begin
               alive_in = 1'b0;
               kind_in  = '0;
               gen_in   = '0;
               pend_in  = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alive_ff     <= 1'b0;
         kind_ff      <= '0;
         gen_ff       <= '0;
         pend_ff      <= '0;
         tok_ff.valid <= 1'b0;
      end else begin
         alive_ff     <= alive_in;
         kind_ff      <= kind_in;
         gen_ff       <= gen_in;
         pend_ff      <= pend_in;
         tok_ff.valid <= tok_in_next.valid;
      end
      tok_ff.op      <= tok_in_next.op;
      tok_ff.kind    <= tok_in_next.kind;
      tok_ff.hslot   <= tok_in_next.hslot;
      tok_ff.hgen    <= tok_in_next.hgen;
      tok_ff.claimed <= tok_in_next.claimed;
      tok_ff.status  <= tok_in_next.status;
      tok_ff.nslot   <= tok_in_next.nslot;
      tok_ff.ngen    <= tok_in_next.ngen;
      tok_ff.cnt     <= tok_in_next.cnt;
   end

   assign tok_out = tok_ff;

endmodule

`default_nettype wire

// ===== rtl/signal_subscription_table.sv =====
// Top level of the signal subscription table: request intake, the row of slot
// cells, the shutdown flag and mask, and the result register. Uses sst_pkg and
// sst_cell, and the assertion macros of signal_subscription_table_assert.svh.
//
// Requests arrive as beats on the req_ channel: the operation code in tuser,
// kind and handle in tdata. Each request yields exactly one result beat on the
// rsp_ channel: status in tuser, new handle, taken count and shutdown flag in
// tdata. A request beat walks the row of SLOTS cells, one cell per cycle; it is
// registered at intake, in each cell, at the row end and in the output register,
// and the next request is taken only once its result has left the row end.
// One request is in the row at a time; req_tready is low while it walks.
// When the receiver stalls, the waiting result stays in the output register and
// a following request is still taken; its result is held at the end of the row
// until the output register frees, and no further request is taken meanwhile.
// Reset empties every slot, zeroes generations and counts, clears the shutdown
// flag and sets the shutdown kind mask to kinds 0 and 1. The user writes the mask via
// csr_wr_en/csr_wr_data only while no request is in progress; the block does not check.
`default_nettype none
`include "signal_subscription_table_assert.svh"

module signal_subscription_table (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // Bits from low: kind[3:0], handle_slot[11:4], handle_generation[43:12], zero fill.
   input  wire [sst_pkg::REQ_DATA_W-1:0]    req_tdata,
   // Bits from low: req_type[2:0].
   input  wire [sst_pkg::OP_W-1:0]          req_tuser,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // Bits from low: new_slot[7:0], new_generation[39:8], count[55:40],
   // shutdown_requested[56], zero fill.
   output logic [sst_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // Bits from low: status[1:0].
   output logic [sst_pkg::ST_W-1:0]         rsp_tuser,
   input  wire                              csr_wr_en,
   input  wire [sst_pkg::MASK_W-1:0]        csr_wr_data
);
   import sst_pkg::*;

   logic                 req_accept;
   logic                 busy_ff, busy_in;
   logic [MASK_W-1:0]    mask_ff, mask_in;
   logic                 shut_ff, shut_in;
   token_type            head_ff, head_in;
   token_type            chain [0:SLOTS];
   logic [SLOTS:0]       chain_valid;
   token_type            fin_ff, fin_in;
   logic                 fin_move;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ST_W-1:0]      rsp_status_ff;
   logic [HSLOT_W-1:0]   rsp_slot_ff;
   logic [GEN_W-1:0]     rsp_gen_ff;
   logic [CNT_W-1:0]     rsp_cnt_ff;
   logic                 rsp_shut_ff;
   logic [CNT_W+COUNT_BITS-1:0] cnt_wide;
   logic [OP_W-1:0]      in_op;
   logic [KIND_W-1:0]    in_kind;

   assign req_tready = !busy_ff;
   assign req_accept = req_tvalid && req_tready;
   assign in_op      = req_tuser;
   assign in_kind    = req_tdata[KIND_W-1:0];
   assign fin_move   = fin_ff.valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      head_in         = head_ff;
      head_in.valid   = req_accept;
      shut_in         = shut_ff;
      mask_in         = csr_wr_en ? csr_wr_data : mask_ff;
      if (req_accept) begin
         head_in.op      = in_op;
         head_in.kind    = in_kind;
         head_in.hslot   = req_tdata[KIND_W +: HSLOT_W];
         head_in.hgen    = req_tdata[KIND_W+HSLOT_W +: GEN_W];
         head_in.claimed = 1'b0;
         head_in.nslot   = '0;
         head_in.ngen    = '0;
         head_in.cnt     = '0;
         if (in_op == OP_SUBSCRIBE) begin
            head_in.status = ST_FULL;
         end else if (in_op inside {OP_POLL, OP_UNSUBSCRIBE}) begin
            head_in.status = ST_NOT_FOUND;
         end else begin
            head_in.status = ST_OK;
         end
         case (in_op)
            OP_RAISE: begin
               if (mask_ff[in_kind]) begin
                  shut_in = 1'b1;
               end
            end
            OP_CLEAR_SHUT, OP_CLEAR_ALL: begin
               shut_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   assign chain[0] = head_ff;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      sst_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (SLOT_BITS'(i)),
         .tok_in     (chain[i]),
         .tok_out    (chain[i+1])
      );
   end

   for (genvar j = 0; j <= SLOTS; j++) begin : g_valid
      assign chain_valid[j] = chain[j].valid;
   end

   always_comb begin
      fin_in = fin_ff;
      if (chain[SLOTS].valid) begin
         fin_in = chain[SLOTS];
      end else if (fin_move) begin
         fin_in.valid = 1'b0;
      end
      busy_in = busy_ff;
      if (req_accept) begin
         busy_in = 1'b1;
      end else if (fin_move) begin
         busy_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fin_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign cnt_wide = {CNT_W'(0), fin_ff.cnt};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         mask_ff      <= MASK_RESET;
         shut_ff      <= 1'b0;
         head_ff.valid <= 1'b0;
         fin_ff.valid <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         mask_ff      <= mask_in;
         shut_ff      <= shut_in;
         head_ff.valid <= head_in.valid;
         fin_ff.valid <= fin_in.valid;
         rsp_valid_ff <= rsp_valid_in;
      end
      head_ff.op      <= head_in.op;
      head_ff.kind    <= head_in.kind;
      head_ff.hslot   <= head_in.hslot;
      head_ff.hgen    <= head_in.hgen;
      head_ff.claimed <= head_in.claimed;
      head_ff.status  <= head_in.status;
      head_ff.nslot   <= head_in.nslot;
      head_ff.ngen    <= head_in.ngen;
      head_ff.cnt     <= head_in.cnt;
      fin_ff.op       <= fin_in.op;
      fin_ff.kind     <= fin_in.kind;
      fin_ff.hslot    <= fin_in.hslot;
      fin_ff.hgen     <= fin_in.hgen;
      fin_ff.claimed  <= fin_in.claimed;
      fin_ff.status   <= fin_in.status;
      fin_ff.nslot    <= fin_in.nslot;
      fin_ff.ngen     <= fin_in.ngen;
      fin_ff.cnt      <= fin_in.cnt;
      if (fin_move) begin
         rsp_status_ff <= fin_ff.status;
         rsp_slot_ff   <= fin_ff.nslot;
         rsp_gen_ff    <= fin_ff.ngen;
         rsp_cnt_ff    <= cnt_wide[CNT_W-1:0];
         rsp_shut_ff   <= shut_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {(RSP_DATA_W-HSLOT_W-GEN_W-CNT_W-1)'(0), rsp_shut_ff, rsp_cnt_ff,
                        rsp_gen_ff, rsp_slot_ff};

   `SST_ASSERT_ALWAYS(a_reset_idle, reset |=> !busy_ff, "Block busy right after reset.")
   `SST_ASSERT(a_accept_busy, req_accept |=> busy_ff, "Request accepted but block not busy.")
   `SST_ASSERT(a_one_beat, $countones(chain_valid) <= 1, "More than one beat in the cell row.")
   `SST_ASSERT(a_no_overrun, chain[SLOTS].valid |-> !fin_ff.valid, "Result lost at row end.")
   `SST_ASSERT(a_busy_track, (chain_valid != '0) |-> busy_ff, "Beat in row while not busy.")

endmodule

`default_nettype wire
